// ----- rtl/sfc_pkg.sv -----
// ----------------------------------------------------------------------------
// sfc_pkg
// Shared types, codes and reset values for the stair floor counter.
// ----------------------------------------------------------------------------
package sfc_pkg;

    localparam int STEP_W   = 24;
    localparam int ALT_W    = 24;
    localparam int COUNT_W  = 16;
    localparam int HEIGHT_W = 16;
    localparam int TICK_W   = 8;
    localparam int MINST_W  = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [HEIGHT_W-1:0] FLOOR_HEIGHT_RST = HEIGHT_W'(300);
    localparam logic [TICK_W-1:0]   REFRESH_RST      = TICK_W'(30);
    localparam logic [MINST_W-1:0]  MIN_STEPS_RST    = MINST_W'(10);

    typedef enum logic [1:0] {
        MODE_TICK  = 2'd0,
        MODE_START = 2'd1,
        MODE_PAUSE = 2'd2,
        MODE_CONT  = 2'd3
    } t_mode;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FLOOR_HEIGHT = 2'd0,
        REG_REFRESH      = 2'd1,
        REG_MIN_STEPS    = 2'd2
    } t_reg_idx;

    typedef struct packed {
        logic [HEIGHT_W-1:0] floor_height;
        logic [TICK_W-1:0]   refresh_ticks;
        logic [MINST_W-1:0]  min_steps;
    } t_cfg;

    typedef struct packed {
        logic                     paused;
        logic [COUNT_W-1:0]       floors_up;
        logic [COUNT_W-1:0]       floors_down;
        logic [STEP_W-1:0]        base_steps;
        logic signed [ALT_W-1:0]  base_height;
        logic [TICK_W-1:0]        tick_count;
    } t_state;

endpackage

// ----- rtl/sfc_step.sv -----
// ----------------------------------------------------------------------------
// sfc_step
// Next-state logic for one item: tick, base refresh, floor test, mode actions.
// ----------------------------------------------------------------------------
module sfc_step (
    input  sfc_pkg::t_cfg                       i_cfg,
    input  sfc_pkg::t_state                     i_state,
    input  logic [1:0]                          i_mode,
    input  logic [sfc_pkg::STEP_W-1:0]          i_total_step,
    input  logic signed [sfc_pkg::ALT_W-1:0]    i_altitude,
    output sfc_pkg::t_state                     o_state
);
    import sfc_pkg::*;

    logic [TICK_W-1:0]        tick_inc;
    logic                     refresh;
    logic [STEP_W-1:0]        eff_steps;
    logic signed [ALT_W-1:0]  eff_height;
    logic signed [ALT_W:0]    diff;
    logic [ALT_W:0]           mag;
    logic [STEP_W-1:0]        walked;
    logic                     height_hit;
    logic                     steps_ok;
    logic                     going_up;

    always_comb begin
        tick_inc   = i_state.tick_count + TICK_W'(1);
        refresh    = tick_inc > i_cfg.refresh_ticks;
        // periodic refresh re-takes the base before the floor test
        eff_steps  = refresh ? i_total_step : i_state.base_steps;
        eff_height = refresh ? i_altitude   : i_state.base_height;
        diff       = {i_altitude[ALT_W-1], i_altitude} - {eff_height[ALT_W-1], eff_height};
        mag        = diff[ALT_W] ? (ALT_W+1)'(-diff) : diff;
        height_hit = mag >= {{(ALT_W+1-HEIGHT_W){1'b0}}, i_cfg.floor_height};
        walked     = i_total_step - eff_steps;
        steps_ok   = (i_total_step > eff_steps) &&
                     (walked >= {{(STEP_W-MINST_W){1'b0}}, i_cfg.min_steps});
        going_up   = !diff[ALT_W] && (diff != '0);
    end

    always_comb begin
        o_state = i_state;
        case (t_mode'(i_mode))
            MODE_START: begin
                o_state.paused      = 1'b0;
                o_state.floors_up   = '0;
                o_state.floors_down = '0;
                o_state.tick_count  = '0;
                o_state.base_steps  = i_total_step;
                o_state.base_height = i_altitude;
            end
            MODE_PAUSE: begin
                o_state.paused = 1'b1;
            end
            MODE_CONT: begin
                o_state.paused      = 1'b0;
                o_state.tick_count  = '0;
                o_state.base_steps  = i_total_step;
                o_state.base_height = i_altitude;
            end
            MODE_TICK: begin
                if (!i_state.paused) begin
                    o_state.tick_count  = refresh ? '0 : tick_inc;
                    o_state.base_steps  = eff_steps;
                    o_state.base_height = eff_height;
                    if (height_hit) begin
                        if (steps_ok && going_up) begin
                            o_state.floors_up = i_state.floors_up + COUNT_W'(1);
                        end else if (steps_ok) begin
                            o_state.floors_down = i_state.floors_down + COUNT_W'(1);
                        end
                        o_state.tick_count  = '0;
                        o_state.base_steps  = i_total_step;
                        o_state.base_height = i_altitude;
                    end
                end
            end
            default: begin
                o_state = i_state;
            end
        endcase
    end

endmodule

// ----- rtl/stair_floor_counter_unit.sv -----
// ----------------------------------------------------------------------------
// stair_floor_counter_unit
// Floor counter driven by a per-second tick of step total and altitude.
// ----------------------------------------------------------------------------
// Takes one item per clock cycle when the input is not stalled. Each item
// passes an input register, then the floor logic updates the counter state
// and loads the result register, which presents the result. A stalled
// output side holds the item in the input register. The state written by one
// item is seen by the very next one. Configuration registers are written
// through the plain write port and take effect for the items that follow.
module stair_floor_counter_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [1:0]                          i_mode,
    input  logic [sfc_pkg::STEP_W-1:0]          i_total_step,
    input  logic signed [sfc_pkg::ALT_W-1:0]    i_altitude,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic [sfc_pkg::COUNT_W-1:0]         o_up_count,
    output logic [sfc_pkg::COUNT_W-1:0]         o_down_count,
    input  logic                                i_cfg_we,
    input  logic [sfc_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [sfc_pkg::CFG_DATA_W-1:0]      i_cfg_data
);
    import sfc_pkg::*;

    t_cfg                     r_cfg;
    t_state                   r_state;
    t_state                   n_state;
    logic                     r_in_valid;
    logic [1:0]               r_mode;
    logic [STEP_W-1:0]        r_total_step;
    logic signed [ALT_W-1:0]  r_altitude;
    logic                     r_out_valid;
    logic [COUNT_W-1:0]       r_up_count;
    logic [COUNT_W-1:0]       r_down_count;
    logic                     advance;
    logic                     in_accept;

    // process stage moves when the result register is free or being taken
    assign advance    = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !advance;
    assign in_accept  = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.floor_height  <= FLOOR_HEIGHT_RST;
            r_cfg.refresh_ticks <= REFRESH_RST;
            r_cfg.min_steps     <= MIN_STEPS_RST;
        end else if (i_cfg_we) begin
            case (t_reg_idx'(i_cfg_index))
                REG_FLOOR_HEIGHT: r_cfg.floor_height  <= i_cfg_data[HEIGHT_W-1:0];
                REG_REFRESH:      r_cfg.refresh_ticks <= i_cfg_data[TICK_W-1:0];
                REG_MIN_STEPS:    r_cfg.min_steps     <= i_cfg_data[MINST_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_accept) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_mode       <= i_mode;
            r_total_step <= i_total_step;
            r_altitude   <= i_altitude;
        end
    end

    sfc_step u_step (
        .i_cfg        (r_cfg),
        .i_state      (r_state),
        .i_mode       (r_mode),
        .i_total_step (r_total_step),
        .i_altitude   (r_altitude),
        .o_state      (n_state)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (advance) begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_up_count   <= n_state.floors_up;
            r_down_count <= n_state.floors_down;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_up_count   = r_up_count;
    assign o_down_count = r_down_count;

endmodule

// ----- rtl/sfc_checker.sv -----
// ----------------------------------------------------------------------------
// sfc_checker
// Port-level checks on the floor counter handshakes, bound to the top level.
// ----------------------------------------------------------------------------
module sfc_checker (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                o_in_stall,
    input  logic                                o_out_valid,
    input  logic                                i_out_stall,
    input  logic [sfc_pkg::COUNT_W-1:0]         o_up_count,
    input  logic [sfc_pkg::COUNT_W-1:0]         o_down_count
);
    import sfc_pkg::*;

    // reset leaves both sides empty
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_stall)
        else $error("outputs not empty after reset");

    // input only backs up when a result is waiting and stalled
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid && i_out_stall)
        else $error("input stalled without a stalled result");

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=>
            o_out_valid && $stable(o_up_count) && $stable(o_down_count))
        else $error("stalled result changed");

endmodule

bind stair_floor_counter_unit sfc_checker u_sfc_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_in_stall   (o_in_stall),
    .o_out_valid  (o_out_valid),
    .i_out_stall  (i_out_stall),
    .o_up_count   (o_up_count),
    .o_down_count (o_down_count)
);
